@@ rtl/core/double_ended_queue_unit_assert.svh @@
// Assertion macros for the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, ignored while reset is asserted.
`define DEQU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deque assertion failed");
// Clocked check that also holds during reset.
`define DEQU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("deque assertion failed");
`else
`define DEQU_ASSERT(label, clk, rst_n, prop)
`define DEQU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/core/deq_pkg.sv @@
package deq_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                     command;
        logic signed [DATA_W-1:0] data_in;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data_out;
        logic                     is_dump_item;
        logic                     last;
    } t_rsp;

    // Operation broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHR,    // push front: everything moves one place back
        CELL_SHL,    // pop front: everything moves one place forward
        CELL_ROT,    // dump step: live part rotates, head goes to tail
        CELL_PUSHB,  // first empty cell takes the value
        CELL_POPB    // tail cell drops out
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctl;

endpackage

@@ rtl/core/deq_cell.sv @@
module deq_cell
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_left_val,
    input  logic                     i_left_vld,
    input  logic signed [DATA_W-1:0] i_right_val,
    input  logic                     i_right_vld,
    input  logic signed [DATA_W-1:0] i_head_val,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_vld,
    output logic signed [DATA_W-1:0] o_tail_val
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     r_vld;
    logic                     n_vld;
    logic                     w_tail;

    assign w_tail     = r_vld && !i_right_vld;
    assign o_val      = r_val;
    assign o_vld      = r_vld;
    assign o_tail_val = w_tail ? r_val : '0;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        case (i_ctl.op)
            CELL_SHR: begin
                n_val = i_left_val;
                n_vld = i_left_vld;
            end
            CELL_SHL: begin
                n_val = i_right_val;
                n_vld = i_right_vld;
            end
            CELL_ROT: begin
                if (w_tail) begin
                    n_val = i_head_val;
                end else if (r_vld) begin
                    n_val = i_right_val;
                end
            end
            CELL_PUSHB: begin
                if (!r_vld && i_left_vld) begin
                    n_val = i_ctl.data;
                    n_vld = 1'b1;
                end
            end
            CELL_POPB: begin
                if (w_tail) begin
                    n_vld = 1'b0;
                end
            end
            default: begin
                n_val = r_val;
                n_vld = r_vld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

@@ rtl/core/double_ended_queue_unit.sv @@
// Bounded double-ended queue of DEPTH signed 32-bit values, built as a row of
// cells: cell 0 always holds the front element and the live elements sit
// packed behind it, each cell with its own valid bit. Push front and pop front
// shift the whole row by one place; push back fills the first empty cell; pop
// back empties the tail cell. Each push or pop request gives one response
// (status ok, full or empty; popped value on a pop).
// A dump request of N stored elements gives N responses, one per cycle while
// the response side does not stall, front to back with last on the final one;
// the live part of the row rotates once per response, so after N steps the
// contents are back in place. Requests are held off (o_req_stall) until the
// remaining N-1 dump responses are loaded, and whenever the response register
// is full and stalled. An empty dump gives one empty status. Commands 5 to 7
// are taken and give no response.
`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_stall,
    // response channel
    output logic o_rsp_valid,
    output t_rsp o_rsp,
    input  logic i_rsp_stall
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state     r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;   // live elements
    logic [CNT_W-1:0] r_left, n_left;     // dump responses still to send
    t_rsp       r_rsp, n_rsp;
    logic       r_rsp_vld, n_rsp_vld;

    t_cell_ctl  w_ctl;
    logic signed [DATA_W-1:0] w_val      [DEPTH];
    logic signed [DATA_W-1:0] w_tail_val [DEPTH];
    logic [DEPTH-1:0]         w_vld;
    logic signed [DATA_W-1:0] w_back_val;

    logic w_out_free;
    logic w_req_fire;
    logic w_full;
    logic w_empty;

    assign w_out_free  = !r_rsp_vld || !i_rsp_stall;
    assign o_req_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_req_fire  = i_req_valid && !o_req_stall;
    assign w_full      = w_vld[DEPTH-1];
    assign w_empty     = !w_vld[0];

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    // ------------------------------------------------------------------
    // Cell row. Cell 0 sees the pushed value as its left neighbor, always
    // valid, which serves both push front and push into an empty row.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_lv;
        logic                     w_lvld;
        logic signed [DATA_W-1:0] w_rv;
        logic                     w_rvld;

        if (g == 0) begin : g_first
            assign w_lv   = i_req.data_in;
            assign w_lvld = 1'b1;
        end else begin : g_mid_l
            assign w_lv   = w_val[g-1];
            assign w_lvld = w_vld[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rv   = '0;
            assign w_rvld = 1'b0;
        end else begin : g_mid_r
            assign w_rv   = w_val[g+1];
            assign w_rvld = w_vld[g+1];
        end

        deq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left_val  (w_lv),
            .i_left_vld  (w_lvld),
            .i_right_val (w_rv),
            .i_right_vld (w_rvld),
            .i_head_val  (w_val[0]),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g]),
            .o_tail_val  (w_tail_val[g])
        );
    end

    // Only the tail cell drives a nonzero value, so an OR picks the back.
    always_comb begin
        w_back_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_val = w_back_val | w_tail_val[k];
        end
    end

    // ------------------------------------------------------------------
    // Control: decode the request, drive the row, load the response.
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_rsp     = r_rsp;
        n_rsp_vld = r_rsp_vld && i_rsp_stall;
        w_ctl.op   = CELL_HOLD;
        w_ctl.data = i_req.data_in;

        case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    n_rsp.status       = ST_OK;
                    n_rsp.data_out     = '0;
                    n_rsp.is_dump_item = 1'b0;
                    n_rsp.last         = 1'b1;
                    n_rsp_vld          = 1'b1;
                    case (i_req.command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (w_full) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                w_ctl.op = (i_req.command == CMD_PUSH_FRONT) ?
                                           CELL_SHR : CELL_PUSHB;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_rsp.status = ST_EMPTY;
                            end else if (i_req.command == CMD_POP_FRONT) begin
                                w_ctl.op       = CELL_SHL;
                                n_rsp.data_out = w_val[0];
                                n_count        = r_count - CNT_W'(1);
                            end else begin
                                w_ctl.op       = CELL_POPB;
                                n_rsp.data_out = w_back_val;
                                n_count        = r_count - CNT_W'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (w_empty) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                // first element goes out now, the rest follow
                                w_ctl.op           = CELL_ROT;
                                n_rsp.data_out     = w_val[0];
                                n_rsp.is_dump_item = 1'b1;
                                n_rsp.last         = (r_count == CNT_W'(1));
                                n_left             = r_count - CNT_W'(1);
                                if (r_count != CNT_W'(1)) begin
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        default: begin
                            n_rsp_vld = r_rsp_vld && i_rsp_stall;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_ctl.op           = CELL_ROT;
                    n_rsp.status       = ST_OK;
                    n_rsp.data_out     = w_val[0];
                    n_rsp.is_dump_item = 1'b1;
                    n_rsp.last         = (r_left == CNT_W'(1));
                    n_rsp_vld          = 1'b1;
                    n_left             = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // live cells stay packed from the front of the row
    `DEQU_ASSERT(a_vld_packed, i_clk, i_rst_n, (w_vld & (w_vld + DEPTH'(1))) == '0)
    // element count tracks the cell valid bits
    `DEQU_ASSERT(a_count_match, i_clk, i_rst_n, r_count == CNT_W'($countones(w_vld)))
    // no request is taken while a dump is streaming
    `DEQU_ASSERT(a_dump_blocks, i_clk, i_rst_n, (r_state == S_DUMP) |-> o_req_stall)
    // a dump leaves the element count unchanged
    `DEQU_ASSERT(a_dump_keeps, i_clk, i_rst_n, (r_state == S_DUMP) |=> (r_count == $past(r_count)))

endmodule
